// ===== design/b64e_pkg.sv =====
// Shared types and constants for the base64 stream encoder.
// Holds the group descriptor passed from front to back and the alphabet map.
// No dependencies.
package b64e_pkg;

  localparam logic [6:0] PadChar = 7'h3D;

  typedef struct packed {
    logic            last;
    logic [2:0]      n_data;
    logic [2:0]      n_total;
    logic [3:0][5:0] sextets;
  } grp_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26) begin
      c = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'd97 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      c = 7'd48 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

// ===== design/b64e_front.sv =====
// Front end of the base64 stream encoder: accepts byte beats, gathers groups.
// Emits one group descriptor per completed or final group. Depends on b64e_pkg.
module b64e_front import b64e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output grp_t       q_grp_o
);

  logic       omit_q;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0][7:0] pend_q;
  logic       accept;
  logic       done;
  logic [7:0] b0, b1, b2;
  logic [2:0] n_data;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign done       = (cnt_q == 2'd2) || in_last_i;
  assign q_push_o   = accept && done;

  always_comb begin
    b0 = (cnt_q == 2'd0) ? in_byte_i : pend_q[0];
    b1 = (cnt_q == 2'd1) ? in_byte_i : ((cnt_q == 2'd2) ? pend_q[1] : 8'd0);
    b2 = (cnt_q == 2'd2) ? in_byte_i : 8'd0;
    n_data = {1'b0, cnt_q} + 3'd2;
    q_grp_o.last       = in_last_i;
    q_grp_o.n_data     = n_data;
    q_grp_o.n_total    = omit_q ? n_data : 3'd4;
    q_grp_o.sextets[0] = b0[7:2];
    q_grp_o.sextets[1] = {b0[1:0], b1[7:4]};
    q_grp_o.sextets[2] = {b1[3:0], b2[7:6]};
    q_grp_o.sextets[3] = b2[5:0];
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = done ? 2'd0 : cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      omit_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        omit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !done) begin
      pend_q[cnt_q[0]] <= in_byte_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("pending count out of range");

endmodule

// ===== design/b64e_fifo.sv =====
// Short group queue between front and back of the base64 stream encoder.
// Register array with read and write pointers. Depends on b64e_pkg.
module b64e_fifo import b64e_pkg::*; #(
  parameter int unsigned QDepth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  grp_t grp_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output grp_t grp_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  grp_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign grp_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= grp_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("group pushed into full queue");

endmodule

// ===== design/b64e_back.sv =====
// Back end of the base64 stream encoder: walks one group a character at a time.
// Maps sextets to ASCII, appends pads, drives the output register. Depends on b64e_pkg.
module b64e_back import b64e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  grp_t       q_grp_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] out_char_o,
  output logic       out_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [6:0] chr_q, chr_d;
  logic       lst_q, lst_d;
  logic       load;
  logic       grp_end;

  assign load    = !q_empty_i && (!vld_q || out_ready_i);
  assign grp_end = ({1'b0, idx_q} == (q_grp_i.n_total - 3'd1));
  assign q_pop_o = load && grp_end;

  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    chr_d = chr_q;
    lst_d = lst_q;
    if (out_ready_i) begin
      vld_d = 1'b0;
    end
    if (load) begin
      vld_d = 1'b1;
      chr_d = ({1'b0, idx_q} < q_grp_i.n_data) ?
              sextet_char(q_grp_i.sextets[idx_q]) : PadChar;
      lst_d = q_grp_i.last && grp_end;
      idx_d = grp_end ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chr_q <= chr_d;
    lst_q <= lst_d;
  end

  assign out_valid_o = vld_q;
  assign out_char_o  = chr_q;
  assign out_last_o  = lst_q;

  a_mid_grp_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> !q_empty_i)
    else $error("group left queue before all characters were sent");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty_i |-> ({1'b0, idx_q} < q_grp_i.n_total))
    else $error("character index beyond group length");

endmodule

// ===== design/base64_stream_encoder.sv =====
// Base64 stream encoder: one byte beat in, one ASCII character beat out.
// A group is queued as its last beat is accepted; the back end then registers its characters.
// Throughput: one character per cycle while m_axis_tready is high and a group
// is queued, set by the back end walking it; a full group of 3 bytes leaves as 4 characters.
// Reset (rst_ni low, asynchronous) empties the pending store, queue and output;
// omit_padding returns to 0.
module base64_stream_encoder import b64e_pkg::*; #(
  parameter int unsigned QDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,    // omit_padding
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] code_char, [7] zero
  output logic       m_axis_tlast
);

  logic       push, full, pop, empty;
  grp_t       grp_in, grp_out;
  logic [6:0] chr;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .q_full_i    (full),
    .q_push_o    (push),
    .q_grp_o     (grp_in)
  );

  b64e_fifo #(
    .QDepth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .grp_i   (grp_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .grp_o   (grp_out)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .q_grp_i     (grp_out),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (chr),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, chr};

endmodule
